// ===== rtl/kat_pkg.sv =====
// ----------------------------------------------------------------------------
// kat_pkg
// shared types and constants of the keyed account table
// ----------------------------------------------------------------------------
package kat_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 20;
    localparam int BAL_W        = 32;
    localparam int AMT_W        = 31;
    localparam int POS_W        = 7;
    localparam int CNT_OUT_W    = 7;

    localparam logic [KEY_W-1:0] KEY_LOW  = 20'd100000;
    localparam logic [KEY_W-1:0] KEY_HIGH = 20'd999999;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_DELETE = 3'd2,
        OP_TXN    = 3'd3,
        OP_FLAG   = 3'd4,
        OP_SORT   = 3'd5,
        OP_READ   = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BAD_KEY   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_BAD_POS   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_SRT_NEXT,
        S_SRT_LOAD,
        S_SRT_CMP,
        S_SRT_CHK,
        S_SRT_PLACE,
        S_READ_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [BAL_W-1:0] bal;
        logic                    act;
    } t_rec;

    typedef struct packed {
        t_status              status;
        t_rec                 rec;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/kat_mem.sv =====
// ----------------------------------------------------------------------------
// kat_mem
// record store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module kat_mem #(
    parameter int CAPACITY = kat_pkg::CAPACITY_DEF,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  kat_pkg::t_rec i_wdata,
    input  logic [IW-1:0] i_raddr,
    output kat_pkg::t_rec o_rdata
);

    kat_pkg::t_rec mem [CAPACITY];
    kat_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kat_ctrl.sv =====
// ----------------------------------------------------------------------------
// kat_ctrl
// sequencer: scans, shifts and sorts the record store one entry at a time
// ----------------------------------------------------------------------------
module kat_ctrl #(
    parameter int CAPACITY = kat_pkg::CAPACITY_DEF,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int PW = (CW > kat_pkg::POS_W) ? CW : kat_pkg::POS_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_op,
    input  logic [kat_pkg::KEY_W-1:0]       i_account_key,
    input  logic [kat_pkg::POS_W-1:0]       i_slot_position,
    input  logic [kat_pkg::AMT_W-1:0]       i_amount,
    input  logic                            i_is_debit,
    input  logic signed [kat_pkg::BAL_W-1:0] i_balance_in,
    input  logic                            i_active_in,
    input  logic                            i_out_free,
    output logic                            o_done,
    output kat_pkg::t_result                o_res,
    output logic                            o_we,
    output logic [IW-1:0]                   o_waddr,
    output kat_pkg::t_rec                   o_wdata,
    output logic [IW-1:0]                   o_raddr,
    input  kat_pkg::t_rec                   i_rdata
);

    kat_pkg::t_state r_state, n_state;
    kat_pkg::t_op    r_op, n_op;
    kat_pkg::t_rec   r_new, n_new;
    kat_pkg::t_rec   r_rec, n_rec;
    kat_pkg::t_result r_res, n_res;
    logic [kat_pkg::POS_W-1:0] r_pos, n_pos;
    logic [kat_pkg::AMT_W-1:0] r_amt, n_amt;
    logic            r_debit, n_debit;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_j, n_j;

    logic [PW-1:0]   pos_w, cnt_w, in_pos_w, idx_w;
    logic [CW:0]     idx_next;
    logic signed [kat_pkg::BAL_W+1:0] sum;
    logic signed [kat_pkg::BAL_W-1:0] sat_bal;
    kat_pkg::t_rec   upd;

    assign pos_w    = PW'(r_pos);
    assign cnt_w    = PW'(r_count);
    assign in_pos_w = PW'(i_slot_position);
    assign idx_w    = PW'(r_idx);
    assign idx_next = {1'b0, r_idx} + (CW+1)'(1);

    // saturating debit or credit of the entry just read
    always_comb begin
        if (r_debit) begin
            sum = (kat_pkg::BAL_W+2)'(i_rdata.bal) - $signed({3'b000, r_amt});
        end else begin
            sum = (kat_pkg::BAL_W+2)'(i_rdata.bal) + $signed({3'b000, r_amt});
        end
        if (sum > $signed(34'sh0_7FFF_FFFF)) begin
            sat_bal = 32'sh7FFF_FFFF;
        end else if (sum < -$signed(34'sh0_8000_0000)) begin
            sat_bal = 32'sh8000_0000;
        end else begin
            sat_bal = sum[kat_pkg::BAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kat_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_new   <= n_new;
        r_rec   <= n_rec;
        r_res   <= n_res;
        r_pos   <= n_pos;
        r_amt   <= n_amt;
        r_debit <= n_debit;
        r_idx   <= n_idx;
        r_j     <= n_j;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_new   = r_new;
        n_rec   = r_rec;
        n_res   = r_res;
        n_pos   = r_pos;
        n_amt   = r_amt;
        n_debit = r_debit;
        n_count = r_count;
        n_idx   = r_idx;
        n_j     = r_j;
        o_ready = 1'b0;
        o_done  = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_idx[IW-1:0];
        o_wdata = i_rdata;
        o_raddr = r_idx[IW-1:0];
        upd     = i_rdata;

        unique case (r_state)
            kat_pkg::S_IDLE: begin
                o_ready = 1'b1;
                o_raddr = IW'(i_slot_position - kat_pkg::POS_W'(1));
                if (i_valid) begin
                    n_op      = kat_pkg::t_op'(i_op);
                    n_new.key = i_account_key;
                    n_new.bal = i_balance_in;
                    n_new.act = i_active_in;
                    n_pos     = i_slot_position;
                    n_amt     = i_amount;
                    n_debit   = i_is_debit;
                    n_idx     = '0;
                    n_res     = '0;
                    case (kat_pkg::t_op'(i_op))
                        kat_pkg::OP_INSERT: begin
                            if (i_account_key < kat_pkg::KEY_LOW ||
                                i_account_key > kat_pkg::KEY_HIGH) begin
                                n_res.status = kat_pkg::ST_BAD_KEY;
                                n_state      = kat_pkg::S_DONE;
                            end else begin
                                n_state = kat_pkg::S_FIND_RD;
                            end
                        end
                        kat_pkg::OP_LOOKUP, kat_pkg::OP_DELETE,
                        kat_pkg::OP_TXN, kat_pkg::OP_FLAG: begin
                            n_state = kat_pkg::S_FIND_RD;
                        end
                        kat_pkg::OP_SORT: begin
                            n_idx   = CW'(1);
                            n_state = kat_pkg::S_SRT_NEXT;
                        end
                        kat_pkg::OP_READ: begin
                            if (in_pos_w == '0 || in_pos_w > cnt_w) begin
                                n_res.status = kat_pkg::ST_BAD_POS;
                                n_state      = kat_pkg::S_DONE;
                            end else begin
                                n_state = kat_pkg::S_READ_CHK;
                            end
                        end
                        default: begin
                            n_state = kat_pkg::S_DONE;
                        end
                    endcase
                end
            end

            kat_pkg::S_FIND_RD: begin
                if (r_idx == r_count) begin
                    // key not held
                    if (r_op == kat_pkg::OP_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_res.status = kat_pkg::ST_FULL;
                            n_state      = kat_pkg::S_DONE;
                        end else if (pos_w == '0 || {1'b0, pos_w} >
                                     {1'b0, cnt_w} + (PW+1)'(1)) begin
                            n_res.status = kat_pkg::ST_BAD_POS;
                            n_state      = kat_pkg::S_DONE;
                        end else begin
                            n_idx   = r_count;
                            n_state = kat_pkg::S_INS_RD;
                        end
                    end else begin
                        n_res.status = kat_pkg::ST_NOT_FOUND;
                        n_state      = kat_pkg::S_DONE;
                    end
                end else begin
                    n_state = kat_pkg::S_FIND_CHK;
                end
            end

            kat_pkg::S_FIND_CHK: begin
                if (i_rdata.key == r_new.key) begin
                    n_state = kat_pkg::S_DONE;
                    case (r_op)
                        kat_pkg::OP_INSERT: begin
                            n_res.status = kat_pkg::ST_DUPLICATE;
                        end
                        kat_pkg::OP_DELETE: begin
                            n_rec   = i_rdata;
                            n_state = kat_pkg::S_DEL_RD;
                        end
                        kat_pkg::OP_TXN, kat_pkg::OP_FLAG: begin
                            if (r_op == kat_pkg::OP_TXN) begin
                                upd.bal = sat_bal;
                            end else begin
                                upd.act = r_new.act;
                            end
                            o_we      = 1'b1;
                            o_wdata   = upd;
                            n_res.rec = upd;
                        end
                        default: begin
                            n_res.rec = i_rdata;
                        end
                    endcase
                end else begin
                    n_idx   = idx_next[CW-1:0];
                    n_state = kat_pkg::S_FIND_RD;
                end
            end

            // open a slot by moving entries up from the tail
            kat_pkg::S_INS_RD: begin
                if (idx_w == pos_w - PW'(1)) begin
                    o_we      = 1'b1;
                    o_wdata   = r_new;
                    n_res.rec = r_new;
                    n_count   = r_count + CW'(1);
                    n_state   = kat_pkg::S_DONE;
                end else begin
                    o_raddr = IW'(r_idx - CW'(1));
                    n_state = kat_pkg::S_INS_WR;
                end
            end

            kat_pkg::S_INS_WR: begin
                o_we    = 1'b1;
                n_idx   = r_idx - CW'(1);
                n_state = kat_pkg::S_INS_RD;
            end

            // close the gap by moving entries down
            kat_pkg::S_DEL_RD: begin
                if (idx_next >= {1'b0, r_count}) begin
                    n_res.rec = r_rec;
                    n_count   = r_count - CW'(1);
                    n_state   = kat_pkg::S_DONE;
                end else begin
                    o_raddr = idx_next[IW-1:0];
                    n_state = kat_pkg::S_DEL_WR;
                end
            end

            kat_pkg::S_DEL_WR: begin
                o_we    = 1'b1;
                n_idx   = idx_next[CW-1:0];
                n_state = kat_pkg::S_DEL_RD;
            end

            // insertion sort, one entry access per cycle
            kat_pkg::S_SRT_NEXT: begin
                if (r_idx >= r_count) begin
                    n_state = kat_pkg::S_DONE;
                end else begin
                    n_state = kat_pkg::S_SRT_LOAD;
                end
            end

            kat_pkg::S_SRT_LOAD: begin
                n_rec   = i_rdata;
                n_j     = r_idx;
                n_state = kat_pkg::S_SRT_CMP;
            end

            kat_pkg::S_SRT_CMP: begin
                o_raddr = IW'(r_j - CW'(1));
                if (r_j == '0) begin
                    n_state = kat_pkg::S_SRT_PLACE;
                end else begin
                    n_state = kat_pkg::S_SRT_CHK;
                end
            end

            kat_pkg::S_SRT_CHK: begin
                o_waddr = r_j[IW-1:0];
                if (i_rdata.key > r_rec.key) begin
                    o_we    = 1'b1;
                    n_j     = r_j - CW'(1);
                    n_state = kat_pkg::S_SRT_CMP;
                end else begin
                    n_state = kat_pkg::S_SRT_PLACE;
                end
            end

            kat_pkg::S_SRT_PLACE: begin
                o_we    = 1'b1;
                o_waddr = r_j[IW-1:0];
                o_wdata = r_rec;
                n_idx   = idx_next[CW-1:0];
                n_state = kat_pkg::S_SRT_NEXT;
            end

            kat_pkg::S_READ_CHK: begin
                n_res.rec = i_rdata;
                n_state   = kat_pkg::S_DONE;
            end

            kat_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = kat_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = kat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res       = r_res;
        o_res.count = kat_pkg::CNT_OUT_W'(r_count);
    end

endmodule

// ===== rtl/keyed_account_table.sv =====
// ----------------------------------------------------------------------------
// keyed_account_table
// table of account records held in one memory, with insert, lookup, delete,
// transaction, flag, sort and positional read
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         i_valid / o_ready  i_op .. i_active_in
// result    out        o_valid / i_ready  o_status_code .. o_count_out
//
// one item at a time; a key scan reads each entry held in turn, the shift of
// an insert or delete moves one entry at a time and sort is an insertion
// sort, all bound by the single memory read port
// a read by position and a bad key need no key scan
// a waiting result sits in the output register; the sequencer stalls only
// when a second result is ready before the first is taken
// reset clears the count and all handshake state, the memory needs no clear
// ----------------------------------------------------------------------------
module keyed_account_table #(
    parameter int CAPACITY = kat_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [2:0]                       i_op,
    input  logic [kat_pkg::KEY_W-1:0]        i_account_key,
    input  logic [kat_pkg::POS_W-1:0]        i_slot_position,
    input  logic [kat_pkg::AMT_W-1:0]        i_amount,
    input  logic                             i_is_debit,
    input  logic signed [kat_pkg::BAL_W-1:0] i_balance_in,
    input  logic                             i_active_in,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_status_code,
    output logic [kat_pkg::KEY_W-1:0]        o_key_out,
    output logic signed [kat_pkg::BAL_W-1:0] o_balance_out,
    output logic                             o_active_out,
    output logic [kat_pkg::CNT_OUT_W-1:0]    o_count_out
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic             we;
    logic [IW-1:0]    waddr, raddr;
    kat_pkg::t_rec    wdata, rdata;
    logic             done, out_free;
    kat_pkg::t_result res;
    kat_pkg::t_result r_out;
    logic             r_ovalid;

    assign out_free = !r_ovalid || i_ready;

    kat_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_account_key  (i_account_key),
        .i_slot_position(i_slot_position),
        .i_amount       (i_amount),
        .i_is_debit     (i_is_debit),
        .i_balance_in   (i_balance_in),
        .i_active_in    (i_active_in),
        .i_out_free     (out_free),
        .o_done         (done),
        .o_res          (res),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata)
    );

    kat_mem #(.CAPACITY(CAPACITY)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status_code = r_out.status;
    assign o_key_out     = r_out.rec.key;
    assign o_balance_out = r_out.rec.bal;
    assign o_active_out  = r_out.rec.act;
    assign o_count_out   = r_out.count;

endmodule

// ===== rtl/kat_chk.sv =====
// ----------------------------------------------------------------------------
// kat_chk
// port-level checks of the keyed account table
// ----------------------------------------------------------------------------
module kat_chk #(
    parameter int CAPACITY = kat_pkg::CAPACITY_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [2:0]                       o_status_code,
    input logic [kat_pkg::KEY_W-1:0]        o_key_out,
    input logic signed [kat_pkg::BAL_W-1:0] o_balance_out,
    input logic                             o_active_out,
    input logic [kat_pkg::CNT_OUT_W-1:0]    o_count_out
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_status_code) && $stable(o_key_out)
            && $stable(o_balance_out) && $stable(o_count_out))
        else $error("result item changed while stalled");

    // an error result carries no record
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status_code != kat_pkg::ST_OK |->
            o_key_out == '0 && o_balance_out == '0 && o_active_out == 1'b0)
        else $error("error result carries record fields");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CAPACITY > 127) || (32'(o_count_out) <= 32'(CAPACITY)))
        else $error("count beyond capacity");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind keyed_account_table kat_chk #(.CAPACITY(CAPACITY)) u_kat_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status_code(o_status_code),
    .o_key_out    (o_key_out),
    .o_balance_out(o_balance_out),
    .o_active_out (o_active_out),
    .o_count_out  (o_count_out)
);

// ===== test/keyed_account_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_account_table_tb
// drives table operations with random idling on both channels, predicts each
// result from a mirror of the table and compares every field in order
// ----------------------------------------------------------------------------
module keyed_account_table_tb;

    localparam int TABLE_SIZE = kat_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [2:0]                     status;
        logic [kat_pkg::KEY_W-1:0]      key;
        logic [kat_pkg::BAL_W-1:0]      bal;
        logic                           act;
        logic [kat_pkg::CNT_OUT_W-1:0]  count;
    } t_expect;

    class account_scoreboard;
        logic [kat_pkg::KEY_W-1:0]        keys [TABLE_SIZE];
        logic signed [kat_pkg::BAL_W-1:0] bals [TABLE_SIZE];
        logic                             acts [TABLE_SIZE];
        int                               held;
        t_expect                          pending [$];
        int                               errors;
        int                               checked;

        function int find_slot(logic [kat_pkg::KEY_W-1:0] key);
            for (int i = 0; i < held; i++) begin
                if (keys[i] == key) return i;
            end
            return -1;
        endfunction

        function void push_result(kat_pkg::t_status st, int idx,
                                  logic [kat_pkg::KEY_W-1:0] k,
                                  logic [kat_pkg::BAL_W-1:0] b, logic a);
            t_expect e;
            e.status = st;
            e.key    = (idx >= 0) ? k : '0;
            e.bal    = (idx >= 0) ? b : '0;
            e.act    = (idx >= 0) ? a : 1'b0;
            e.count  = held[kat_pkg::CNT_OUT_W-1:0];
            pending.push_back(e);
        endfunction

        function void note_request(logic [2:0] op, logic [kat_pkg::KEY_W-1:0] key,
                                   logic [kat_pkg::POS_W-1:0] pos,
                                   logic [kat_pkg::AMT_W-1:0] amt,
                                   logic debit, logic signed [kat_pkg::BAL_W-1:0] bal_in,
                                   logic act_in);
            int idx;
            longint sum;
            logic [kat_pkg::KEY_W-1:0] k;
            logic [kat_pkg::BAL_W-1:0] b;
            logic a;
            int j;
            case (op)
                kat_pkg::OP_INSERT: begin
                    if (key < kat_pkg::KEY_LOW || key > kat_pkg::KEY_HIGH)
                        push_result(kat_pkg::ST_BAD_KEY, -1, 0, 0, 0);
                    else if (find_slot(key) >= 0)
                        push_result(kat_pkg::ST_DUPLICATE, -1, 0, 0, 0);
                    else if (held >= TABLE_SIZE)
                        push_result(kat_pkg::ST_FULL, -1, 0, 0, 0);
                    else if (pos < 1 || pos > held + 1)
                        push_result(kat_pkg::ST_BAD_POS, -1, 0, 0, 0);
                    else begin
                        for (int i = held; i > pos - 1; i--) begin
                            keys[i] = keys[i-1]; bals[i] = bals[i-1]; acts[i] = acts[i-1];
                        end
                        keys[pos-1] = key; bals[pos-1] = bal_in; acts[pos-1] = act_in;
                        held++;
                        push_result(kat_pkg::ST_OK, pos - 1, key, bal_in, act_in);
                    end
                end
                kat_pkg::OP_LOOKUP, kat_pkg::OP_TXN, kat_pkg::OP_FLAG: begin
                    idx = find_slot(key);
                    if (idx < 0) push_result(kat_pkg::ST_NOT_FOUND, -1, 0, 0, 0);
                    else begin
                        if (op == kat_pkg::OP_TXN) begin
                            sum = longint'(bals[idx]);
                            sum = debit ? sum - longint'(amt) : sum + longint'(amt);
                            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                            bals[idx] = sum[kat_pkg::BAL_W-1:0];
                        end else if (op == kat_pkg::OP_FLAG) begin
                            acts[idx] = act_in;
                        end
                        push_result(kat_pkg::ST_OK, idx, keys[idx], bals[idx], acts[idx]);
                    end
                end
                kat_pkg::OP_DELETE: begin
                    idx = find_slot(key);
                    if (idx < 0) push_result(kat_pkg::ST_NOT_FOUND, -1, 0, 0, 0);
                    else begin
                        k = keys[idx]; b = bals[idx]; a = acts[idx];
                        for (int i = idx; i + 1 < held; i++) begin
                            keys[i] = keys[i+1]; bals[i] = bals[i+1]; acts[i] = acts[i+1];
                        end
                        held--;
                        push_result(kat_pkg::ST_OK, 0, k, b, a);
                    end
                end
                kat_pkg::OP_SORT: begin
                    for (int i = 1; i < held; i++) begin
                        k = keys[i]; b = bals[i]; a = acts[i];
                        j = i;
                        while (j > 0 && keys[j-1] > k) begin
                            keys[j] = keys[j-1]; bals[j] = bals[j-1]; acts[j] = acts[j-1];
                            j--;
                        end
                        keys[j] = k; bals[j] = b; acts[j] = a;
                    end
                    push_result(kat_pkg::ST_OK, -1, 0, 0, 0);
                end
                kat_pkg::OP_READ: begin
                    if (pos < 1 || pos > held) push_result(kat_pkg::ST_BAD_POS, -1, 0, 0, 0);
                    else push_result(kat_pkg::ST_OK, pos - 1, keys[pos-1], bals[pos-1],
                                     acts[pos-1]);
                end
                default: push_result(kat_pkg::ST_OK, -1, 0, 0, 0);
            endcase
        endfunction

        function void check_result(logic [2:0] st, logic [kat_pkg::KEY_W-1:0] key,
                                   logic [kat_pkg::BAL_W-1:0] bal, logic act,
                                   logic [kat_pkg::CNT_OUT_W-1:0] cnt);
            t_expect e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (st !== e.status) begin
                $error("status_code expected %0d got %0d", e.status, st); errors++;
            end
            if (key !== e.key) begin
                $error("key_out expected %0d got %0d", e.key, key); errors++;
            end
            if (bal !== e.bal) begin
                $error("balance_out expected %0d got %0d", $signed(e.bal), $signed(bal));
                errors++;
            end
            if (act !== e.act) begin
                $error("active_out expected %0d got %0d", e.act, act); errors++;
            end
            if (cnt !== e.count) begin
                $error("count_out expected %0d got %0d", e.count, cnt); errors++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic [2:0]                       i_op;
    logic [kat_pkg::KEY_W-1:0]        i_account_key;
    logic [kat_pkg::POS_W-1:0]        i_slot_position;
    logic [kat_pkg::AMT_W-1:0]        i_amount;
    logic                             i_is_debit;
    logic signed [kat_pkg::BAL_W-1:0] i_balance_in;
    logic                             i_active_in;
    logic                             o_valid;
    logic                             i_ready;
    logic [2:0]                       o_status_code;
    logic [kat_pkg::KEY_W-1:0]        o_key_out;
    logic signed [kat_pkg::BAL_W-1:0] o_balance_out;
    logic                             o_active_out;
    logic [kat_pkg::CNT_OUT_W-1:0]    o_count_out;

    account_scoreboard ledger;
    bit                quiet_stretch;
    int                idle_cycles;
    int                sent;
    int                op_seen [8];

    keyed_account_table dut (.*);

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall unless in the quiet stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                ledger.check_result(o_status_code, o_key_out, o_balance_out,
                                    o_active_out, o_count_out);
            i_ready <= quiet_stretch || ($urandom_range(99) >= 27);
        end
    end

    // watchdog on accepted items
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] op, logic [kat_pkg::KEY_W-1:0] key,
                             logic [kat_pkg::POS_W-1:0] pos,
                             logic [kat_pkg::AMT_W-1:0] amt,
                             logic debit, logic [kat_pkg::BAL_W-1:0] bal, logic act);
        // the block drops o_ready after taking each item
        @(posedge i_clk);
        while (!quiet_stretch && $urandom_range(99) < 27) @(posedge i_clk);
        i_valid         <= 1'b1;
        i_op            <= op;
        i_account_key   <= key;
        i_slot_position <= pos;
        i_amount        <= amt;
        i_is_debit      <= debit;
        i_balance_in    <= bal;
        i_active_in     <= act;
        do @(posedge i_clk); while (!o_ready);
        ledger.note_request(op, key, pos, amt, debit, bal, act);
        op_seen[op]++;
        sent++;
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (ledger.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [kat_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && ledger.held > 0) return ledger.keys[$urandom_range(ledger.held - 1)];
        if (r < 65) return 20'($urandom_range(99999));
        if (r < 70) return (r[0]) ? 20'hFFFFF : 20'(1000000 + $urandom_range(48575));
        return 20'($urandom_range(999999, 100000));
    endfunction

    task automatic random_item();
        int r;
        logic [2:0] op;
        logic [kat_pkg::POS_W-1:0] pos;
        logic [kat_pkg::BAL_W-1:0] bal;
        logic [kat_pkg::AMT_W-1:0] amt;
        r = $urandom_range(99);
        // favor inserts while the table is small, deletes when nearly full
        if (r < (ledger.held < 40 ? 35 : 15)) op = kat_pkg::OP_INSERT;
        else if (r < 50) op = kat_pkg::OP_DELETE;
        else op = 3'($urandom_range(7));
        pos = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                       : 7'($urandom_range(ledger.held + 1, 1));
        case ($urandom_range(3))
            0: bal = $urandom;
            1: bal = 32'sh7FFFFF00 + $urandom_range(255);
            2: bal = 32'sh80000000 + $urandom_range(255);
            default: bal = $urandom_range(2000) - 1000;
        endcase
        amt = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(500));
        send_item(op, pick_key(), pos, amt, 1'($urandom), bal, 1'($urandom));
    endtask

    initial begin
        ledger = new();
        quiet_stretch   = 1'b0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_op            = kat_pkg::OP_NONE;
        i_account_key   = '0;
        i_slot_position = '0;
        i_amount        = '0;
        i_is_debit      = 1'b0;
        i_balance_in    = '0;
        i_active_in     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-table errors, key bounds, saturation, all ops
        send_item(kat_pkg::OP_READ,   20'd100000, 7'd1, '0, 0, '0, 0);
        send_item(kat_pkg::OP_LOOKUP, 20'd123456, 7'd0, '0, 0, '0, 0);
        send_item(kat_pkg::OP_INSERT, 20'd99999,  7'd1, '0, 0, '0, 1);
        send_item(kat_pkg::OP_INSERT, 20'd1000000, 7'd1, '0, 0, '0, 1);
        send_item(kat_pkg::OP_INSERT, 20'hFFFFF,  7'd1, '0, 0, '0, 1);
        send_item(kat_pkg::OP_INSERT, 20'd100000, 7'd0, '0, 0, '0, 1);
        send_item(kat_pkg::OP_INSERT, 20'd999999, 7'd1, '0, 0, 32'sh7FFFFFFF, 1);
        send_item(kat_pkg::OP_INSERT, 20'd100000, 7'd2, '0, 0, 32'sh80000000, 0);
        send_item(kat_pkg::OP_INSERT, 20'd500000, 7'd2, '0, 0, 32'sd12, 1);
        send_item(kat_pkg::OP_INSERT, 20'd500000, 7'd1, '0, 0, '0, 1);
        send_item(kat_pkg::OP_INSERT, 20'd600000, 7'd5, '0, 0, '0, 1);
        send_item(kat_pkg::OP_TXN,    20'd999999, 7'd0, 31'h7FFFFFFF, 0, '0, 0);
        send_item(kat_pkg::OP_TXN,    20'd100000, 7'd0, 31'h7FFFFFFF, 1, '0, 0);
        send_item(kat_pkg::OP_TXN,    20'd500000, 7'd0, 31'd5, 1, '0, 0);
        send_item(kat_pkg::OP_FLAG,   20'd500000, 7'd0, '0, 0, '0, 0);
        send_item(kat_pkg::OP_FLAG,   20'd444444, 7'd0, '0, 0, '0, 1);
        send_item(kat_pkg::OP_SORT,   20'd0,      7'd0, '0, 0, '0, 0);
        send_item(kat_pkg::OP_READ,   20'd0,      7'd3, '0, 0, '0, 0);
        send_item(kat_pkg::OP_READ,   20'd0,      7'd4, '0, 0, '0, 0);
        send_item(kat_pkg::OP_READ,   20'd0,      7'h7F, '0, 0, '0, 0);
        send_item(kat_pkg::OP_NONE,   20'hFFFFF,  7'h7F, 31'h7FFFFFFF, 1, 32'hFFFFFFFF, 1);
        send_item(kat_pkg::OP_DELETE, 20'd500000, 7'd0, '0, 0, '0, 0);
        send_item(kat_pkg::OP_DELETE, 20'd500000, 7'd0, '0, 0, '0, 0);

        // hold off until the table has answered everything so far
        wait_drained();

        // fill to capacity to reach the full status
        while (ledger.held < TABLE_SIZE)
            send_item(kat_pkg::OP_INSERT, 20'($urandom_range(999999, 100000)),
                      7'($urandom_range(ledger.held + 1, 1)), '0, 0, 32'($urandom), 1);
        send_item(kat_pkg::OP_INSERT, 20'd777777, 7'd1, '0, 0, '0, 1);
        send_item(kat_pkg::OP_SORT,   20'd0, 7'd0, '0, 0, '0, 0);
        send_item(kat_pkg::OP_READ,   20'd0, 7'd64, '0, 0, '0, 0);
        send_item(kat_pkg::OP_READ,   20'd0, 7'd65, '0, 0, '0, 0);

        for (int n = 0; n < 560; n++) begin
            quiet_stretch = (n >= 200 && n < 300);
            random_item();
        end
        quiet_stretch = 1'b0;

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("ran %0d items: inserts %0d, deletes %0d, txns %0d, sorts %0d, reads %0d",
                 sent, op_seen[kat_pkg::OP_INSERT], op_seen[kat_pkg::OP_DELETE],
                 op_seen[kat_pkg::OP_TXN], op_seen[kat_pkg::OP_SORT],
                 op_seen[kat_pkg::OP_READ]);
        $display("%0d results compared, %0d field errors", ledger.checked, ledger.errors);
        if (ledger.errors == 0 && ledger.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
